@@ hw/rtl/utf8_text_glyph_layout_macros.svh @@
// ----------------------------------------------------------------------------
// utf8 text glyph layout assertion macros
// shared property shorthands, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef UTF8_TEXT_GLYPH_LAYOUT_MACROS_SVH
`define UTF8_TEXT_GLYPH_LAYOUT_MACROS_SVH
`ifndef SYNTHESIS
`define UTL_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("utl assertion failed");
`define UTL_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("utl assertion failed");
`else
`define UTL_ASSERT(lbl, ante, cons)
`define UTL_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/utl_pkg.sv @@
// ----------------------------------------------------------------------------
// utl_pkg
// types and constants of the utf8 text glyph layout block
// ----------------------------------------------------------------------------
package utl_pkg;

	localparam int GLYPH_SIZE  = 16;
	localparam int PEN_ADVANCE = 8;

	localparam logic [2:0] CFG_LEFT       = 3'd0;
	localparam logic [2:0] CFG_TOP        = 3'd1;
	localparam logic [2:0] CFG_BOX_WIDTH  = 3'd2;
	localparam logic [2:0] CFG_BOX_HEIGHT = 3'd3;
	localparam logic [2:0] CFG_CURSOR     = 3'd4;

	localparam logic [1:0] MODE_SKIP   = 2'd0;
	localparam logic [1:0] MODE_GLYPH  = 2'd1;
	localparam logic [1:0] MODE_CURSOR = 2'd2;

	localparam logic [20:0] RUNE_NEWLINE = 21'd10;
	localparam logic [20:0] RUNE_SPACE   = 21'd32;

	typedef struct packed {
		logic [11:0] left;
		logic [11:0] top;
		logic [11:0] box_width;
		logic [11:0] box_height;
		logic [16:0] cursor_index;
	} cfg_t;

	typedef struct packed {
		logic        rune_valid;
		logic        term;
		logic [20:0] rune;
	} dec_t;

	typedef struct packed {
		logic [1:0]  draw_mode;
		logic [12:0] dest_x;
		logic [12:0] dest_y;
		logic [11:0] src_x;
		logic [16:0] src_y;
		logic        last;
		logic [15:0] bytes_used;
	} result_t;

endpackage

@@ hw/rtl/utl_byte_if.sv @@
// ----------------------------------------------------------------------------
// utl_byte_if
// text byte channel, one string byte per word
// ----------------------------------------------------------------------------
interface utl_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink (input valid, input text_byte, output ready);
endinterface

@@ hw/rtl/utl_glyph_if.sv @@
// ----------------------------------------------------------------------------
// utl_glyph_if
// glyph command channel, one command per word
// ----------------------------------------------------------------------------
interface utl_glyph_if;
	logic        valid;
	logic        ready;
	logic [1:0]  draw_mode;
	logic [12:0] dest_x;
	logic [12:0] dest_y;
	logic [11:0] src_x;
	logic [16:0] src_y;
	logic        last;
	logic [15:0] bytes_used;

	modport source (output valid, output draw_mode, output dest_x, output dest_y,
		output src_x, output src_y, output last, output bytes_used, input ready);
	modport sink (input valid, input draw_mode, input dest_x, input dest_y,
		input src_x, input src_y, input last, input bytes_used, output ready);
endinterface

@@ hw/rtl/utl_decode.sv @@
// ----------------------------------------------------------------------------
// utl_decode
// utf8 byte decoder, holds the partial rune between bytes
// ----------------------------------------------------------------------------
module utl_decode (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic          finished,
	input  logic [7:0]    text_byte,
	output utl_pkg::dec_t dec
);
	import utl_pkg::*;

	logic [20:0] accum_q;
	logic [1:0]  pending_q;
	logic [20:0] accum_n;
	logic [1:0]  pending_n;
	logic        zero;

	assign zero = (text_byte == 8'd0);

	always_comb begin
		accum_n        = accum_q;
		pending_n      = pending_q;
		dec.rune_valid = 1'b0;
		dec.term       = 1'b0;
		dec.rune       = 21'd0;
		if (zero) begin
			accum_n        = 21'd0;
			pending_n      = 2'd0;
			dec.rune_valid = 1'b1;
			dec.term       = 1'b1;
		end else if (pending_q != 2'd0) begin
			accum_n        = {accum_q[14:0], text_byte[5:0]};
			pending_n      = pending_q - 2'd1;
			dec.rune_valid = (pending_n == 2'd0);
			dec.rune       = accum_n;
		end else if (text_byte[7:5] == 3'b110) begin
			accum_n   = {16'd0, text_byte[4:0]};
			pending_n = 2'd1;
		end else if (text_byte[7:4] == 4'b1110) begin
			accum_n   = {17'd0, text_byte[3:0]};
			pending_n = 2'd2;
		end else if (text_byte[7:3] == 5'b11110) begin
			accum_n   = {18'd0, text_byte[2:0]};
			pending_n = 2'd3;
		end else begin
			accum_n        = {13'd0, text_byte};
			dec.rune_valid = 1'b1;
			dec.rune       = accum_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q   <= 21'd0;
			pending_q <= 2'd0;
		end else if (step && (zero || !finished)) begin
			accum_q   <= accum_n;
			pending_q <= pending_n;
		end
	end
endmodule

@@ hw/rtl/utl_layout.sv @@
// ----------------------------------------------------------------------------
// utl_layout
// pen, rune index and byte count, builds one glyph command per rune
// ----------------------------------------------------------------------------
`include "utf8_text_glyph_layout_macros.svh"

module utl_layout (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       text_byte,
	input  utl_pkg::cfg_t    cfg,
	input  utl_pkg::dec_t    dec,
	output logic             finished,
	output logic             res_valid,
	output utl_pkg::result_t res
);
	import utl_pkg::*;

	logic [12:0] pen_x_q;
	logic [12:0] pen_y_q;
	logic        in_string_q;
	logic [15:0] rune_index_q;
	logic [15:0] byte_count_q;
	logic        finished_q;

	logic [12:0] pen_x_cur;
	logic [12:0] pen_y_cur;
	logic [15:0] count_n;
	logic        is_cursor;
	logic [20:0] src_rune;
	logic [12:0] x2;
	logic [12:0] y2;
	logic [13:0] nx_adv;
	logic        wrap;
	logic [13:0] nx;
	logic [13:0] ny;
	logic        last;
	logic        zero;

	assign zero      = (text_byte == 8'd0);
	assign finished  = finished_q;
	assign pen_x_cur = in_string_q ? pen_x_q : {1'b0, cfg.left};
	assign pen_y_cur = in_string_q ? pen_y_q : {1'b0, cfg.top};
	assign count_n   = (byte_count_q != 16'hFFFF) ? byte_count_q + 16'd1 : byte_count_q;
	assign is_cursor = !cfg.cursor_index[16] && (cfg.cursor_index[15:0] == rune_index_q);
	assign src_rune  = (is_cursor && dec.rune == 21'd0) ? RUNE_SPACE : dec.rune;

	assign x2     = {1'b0, cfg.left} + {1'b0, cfg.box_width};
	assign y2     = {1'b0, cfg.top} + {1'b0, cfg.box_height};
	assign nx_adv = {1'b0, pen_x_cur} + 14'(PEN_ADVANCE);
	assign wrap   = (nx_adv >= {1'b0, x2}) || (dec.rune == RUNE_NEWLINE);
	assign nx     = wrap ? {2'b00, cfg.left} : nx_adv;
	assign ny     = wrap ? {1'b0, pen_y_cur} + 14'(GLYPH_SIZE) : {1'b0, pen_y_cur};
	assign last   = dec.term || (ny >= {1'b0, y2});

	assign res_valid = step && !finished_q && dec.rune_valid;

	always_comb begin
		if (is_cursor) begin
			res.draw_mode = MODE_CURSOR;
		end else if (dec.rune == RUNE_NEWLINE || dec.rune == RUNE_SPACE) begin
			res.draw_mode = MODE_SKIP;
		end else begin
			res.draw_mode = MODE_GLYPH;
		end
		res.dest_x     = pen_x_cur;
		res.dest_y     = pen_y_cur;
		res.src_x      = 12'(32'(src_rune[7:0]) * GLYPH_SIZE);
		res.src_y      = 17'(32'(src_rune[20:8]) * GLYPH_SIZE);
		res.last       = last;
		res.bytes_used = count_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q      <= 13'd0;
			pen_y_q      <= 13'd0;
			in_string_q  <= 1'b0;
			rune_index_q <= 16'd0;
			byte_count_q <= 16'd0;
			finished_q   <= 1'b0;
		end else if (step) begin
			if (finished_q) begin
				if (zero) begin
					in_string_q  <= 1'b0;
					rune_index_q <= 16'd0;
					byte_count_q <= 16'd0;
					finished_q   <= 1'b0;
				end
			end else if (dec.rune_valid && dec.term) begin
				pen_x_q      <= nx[12:0];
				pen_y_q      <= ny[12:0];
				in_string_q  <= 1'b0;
				rune_index_q <= 16'd0;
				byte_count_q <= 16'd0;
			end else if (dec.rune_valid) begin
				pen_x_q      <= nx[12:0];
				pen_y_q      <= ny[12:0];
				in_string_q  <= 1'b1;
				rune_index_q <= rune_index_q + 16'd1;
				byte_count_q <= count_n;
				finished_q   <= last;
			end else begin
				pen_x_q      <= pen_x_cur;
				pen_y_q      <= pen_y_cur;
				in_string_q  <= 1'b1;
				byte_count_q <= count_n;
			end
		end
	end

	`UTL_ASSERT(a_finished_in_string, finished_q, in_string_q)
	`UTL_ASSERT_NXT(a_zero_restarts, step && zero,
		!in_string_q && !finished_q && rune_index_q == 16'd0 && byte_count_q == 16'd0)
	`UTL_ASSERT_NXT(a_index_advances, res_valid && !dec.term,
		rune_index_q == $past(rune_index_q) + 16'd1)
endmodule

@@ hw/rtl/utf8_text_glyph_layout.sv @@
// ----------------------------------------------------------------------------
// utf8_text_glyph_layout
// utf8 string to glyph command layout engine
// ----------------------------------------------------------------------------
// Takes one string byte per clock and gives at most one glyph command per
// byte, held first in the input register and then in the result register.
// The sustained rate is one byte per cycle; the input stalls only
// while the result register holds a command the sink has not taken. Bytes
// after the box bottom is reached are dropped up to the zero terminator.
// Box registers are read live and should be written only while idle.
module utf8_text_glyph_layout (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_data,
	utl_byte_if.sink    text_in,
	utl_glyph_if.source glyph_out
);
	import utl_pkg::*;

	cfg_t        cfg_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	result_t     out_q;
	logic        advance;
	dec_t        dec;
	logic        finished;
	logic        res_valid;
	result_t     res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left         <= 12'd0;
			cfg_q.top          <= 12'd0;
			cfg_q.box_width    <= 12'd0;
			cfg_q.box_height   <= 12'd0;
			cfg_q.cursor_index <= 17'h1FFFF;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LEFT:       cfg_q.left         <= cfg_data[11:0];
				CFG_TOP:        cfg_q.top          <= cfg_data[11:0];
				CFG_BOX_WIDTH:  cfg_q.box_width    <= cfg_data[11:0];
				CFG_BOX_HEIGHT: cfg_q.box_height   <= cfg_data[11:0];
				CFG_CURSOR:     cfg_q.cursor_index <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign advance       = valid_s1 && (!out_valid_q || glyph_out.ready);
	assign text_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_in.ready) begin
			valid_s1 <= text_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_in.ready && text_in.valid) begin
			byte_s1 <= text_in.text_byte;
		end
	end

	utl_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.finished  (finished),
		.text_byte (byte_s1),
		.dec       (dec)
	);

	utl_layout u_layout (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.text_byte (byte_s1),
		.cfg       (cfg_q),
		.dec       (dec),
		.finished  (finished),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (glyph_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign glyph_out.valid      = out_valid_q;
	assign glyph_out.draw_mode  = out_q.draw_mode;
	assign glyph_out.dest_x     = out_q.dest_x;
	assign glyph_out.dest_y     = out_q.dest_y;
	assign glyph_out.src_x      = out_q.src_x;
	assign glyph_out.src_y      = out_q.src_y;
	assign glyph_out.last       = out_q.last;
	assign glyph_out.bytes_used = out_q.bytes_used;
endmodule

@@ sim/utf8_text_glyph_layout_tb.sv @@
// ----------------------------------------------------------------------------
// utf8_text_glyph_layout_tb
// self-checking bench for the utf8 text glyph layout block
// ----------------------------------------------------------------------------
// Drives string bytes through the text channel and compares every glyph
// command with a cycle-free layout predictor kept in the bench. Directed
// tests cover decode corners, cursor drawing, box edges and live register
// reads; a random part then runs mostly well-formed strings under changing
// box settings. Both channels stall at random.
module utf8_text_glyph_layout_tb;
	import utl_pkg::*;

	localparam int          RESULT_LATENCY = 2;
	localparam int          IDLE_LIMIT     = 200;
	localparam int          RANDOM_BYTES   = 1560;
	localparam int          RANDOM_PHASES  = 8;
	localparam logic [2:0]  CFG_UNUSED     = 3'd7;
	localparam logic [16:0] NO_CURSOR      = 17'h1FFFF;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [16:0] cfg_data;

	utl_byte_if  byte_ch ();
	utl_glyph_if glyph_ch ();

	utf8_text_glyph_layout dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.text_in   (byte_ch),
		.glyph_out (glyph_ch)
	);

	// layout predictor state
	logic [11:0] box_left, box_top, box_w, box_h;
	logic [16:0] cursor_at;
	logic [20:0] rune_acc;
	logic [1:0]  cont_left;
	logic [12:0] pen_x, pen_y;
	logic [15:0] rune_idx, byte_cnt;
	bit          string_done, string_open;

	result_t pending_glyphs[$];
	int      mismatches;
	int      bytes_taken;
	int      idle_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void clear_string();
		rune_acc    = '0;
		cont_left   = '0;
		rune_idx    = '0;
		byte_cnt    = '0;
		string_done = 1'b0;
		string_open = 1'b0;
	endfunction

	function automatic void place_rune(input logic [20:0] rune, input bit term,
		output result_t cmd);
		int unsigned x_edge, y_edge, nx, ny;
		logic [20:0] src;
		bit          at_cursor;
		x_edge    = 32'(box_left) + 32'(box_w);
		y_edge    = 32'(box_top) + 32'(box_h);
		at_cursor = !cursor_at[16] && cursor_at[15:0] == rune_idx;
		src       = rune;
		if (at_cursor) begin
			cmd.draw_mode = MODE_CURSOR;
			if (rune == '0)
				src = RUNE_SPACE;
		end else begin
			cmd.draw_mode = (rune == RUNE_NEWLINE || rune == RUNE_SPACE) ? MODE_SKIP
				: MODE_GLYPH;
		end
		cmd.dest_x     = pen_x;
		cmd.dest_y     = pen_y;
		cmd.src_x      = 12'(32'(src[7:0]) * GLYPH_SIZE);
		cmd.src_y      = 17'(32'(src[20:8]) * GLYPH_SIZE);
		cmd.bytes_used = byte_cnt;
		nx = 32'(pen_x) + PEN_ADVANCE;
		ny = 32'(pen_y);
		if (nx >= x_edge || rune == RUNE_NEWLINE) begin
			ny = 32'(pen_y) + GLYPH_SIZE;
			nx = 32'(box_left);
		end
		cmd.last = term || ny >= y_edge;
		pen_x    = 13'(nx);
		pen_y    = 13'(ny);
		rune_idx = rune_idx + 16'd1;
		if (term)
			clear_string();
		else if (cmd.last)
			string_done = 1'b1;
	endfunction

	// returns 1 when the byte completes a rune and a glyph command follows
	function automatic bit layout_byte(input logic [7:0] b, output result_t cmd);
		cmd = '0;
		if (string_done) begin
			if (b == 8'h00)
				clear_string();
			return 1'b0;
		end
		if (!string_open) begin
			string_open = 1'b1;
			pen_x       = 13'(box_left);
			pen_y       = 13'(box_top);
		end
		if (byte_cnt != 16'hFFFF)
			byte_cnt = byte_cnt + 16'd1;
		if (b == 8'h00) begin
			rune_acc  = '0;
			cont_left = '0;
			place_rune('0, 1'b1, cmd);
			return 1'b1;
		end
		if (cont_left != 2'd0) begin
			rune_acc  = {rune_acc[14:0], b[5:0]};
			cont_left = cont_left - 2'd1;
			if (cont_left != 2'd0)
				return 1'b0;
			place_rune(rune_acc, 1'b0, cmd);
			return 1'b1;
		end
		if (b[7:5] == 3'b110) begin
			rune_acc  = 21'(b[4:0]);
			cont_left = 2'd1;
			return 1'b0;
		end
		if (b[7:4] == 4'b1110) begin
			rune_acc  = 21'(b[3:0]);
			cont_left = 2'd2;
			return 1'b0;
		end
		if (b[7:3] == 5'b11110) begin
			rune_acc  = 21'(b[2:0]);
			cont_left = 2'd3;
			return 1'b0;
		end
		rune_acc = 21'(b);
		place_rune(21'(b), 1'b0, cmd);
		return 1'b1;
	endfunction

	task automatic cfg_write(input logic [2:0] idx, input logic [16:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		case (idx)
			CFG_LEFT:       box_left  = data[11:0];
			CFG_TOP:        box_top   = data[11:0];
			CFG_BOX_WIDTH:  box_w     = data[11:0];
			CFG_BOX_HEIGHT: box_h     = data[11:0];
			CFG_CURSOR:     cursor_at = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_box(input int l, input int t, input int w, input int h,
		input logic [16:0] cur);
		cfg_write(CFG_LEFT, 17'(l));
		cfg_write(CFG_TOP, 17'(t));
		cfg_write(CFG_BOX_WIDTH, 17'(w));
		cfg_write(CFG_BOX_HEIGHT, 17'(h));
		cfg_write(CFG_CURSOR, cur);
	endtask

	task automatic send_byte(input logic [7:0] b);
		int      gap;
		result_t cmd;
		gap = $urandom_range(0, 9);
		if (gap != 0) begin
			byte_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_ch.valid     = 1'b1;
		byte_ch.text_byte = b;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		bytes_taken++;
		if (layout_byte(b, cmd))
			pending_glyphs.push_back(cmd);
		@(negedge clk);
	endtask

	task automatic send_bytes(input logic [7:0] bytes[$]);
		foreach (bytes[i])
			send_byte(bytes[i]);
	endtask

	task automatic drain();
		byte_ch.valid = 1'b0;
		while (pending_glyphs.size() != 0)
			@(negedge clk);
		repeat (RESULT_LATENCY + 4) @(negedge clk);
	endtask

	task automatic send_rune_random();
		logic [20:0] r;
		r = 21'($urandom);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				if ($urandom_range(0, 9) == 0)
					send_byte($urandom_range(0, 1) ? 8'h20 : 8'h0A);
				else
					send_byte(8'($urandom_range(1, 127)));
			end
			5, 6: begin
				send_byte({3'b110, r[10:6]});
				send_byte({2'b10, r[5:0]});
			end
			7, 8: begin
				send_byte({4'b1110, r[15:12]});
				send_byte({2'b10, r[11:6]});
				send_byte({2'b10, r[5:0]});
			end
			default: begin
				send_byte({5'b11110, r[20:18]});
				send_byte({2'b10, r[17:12]});
				send_byte({2'b10, r[11:6]});
				send_byte({2'b10, r[5:0]});
			end
		endcase
	endtask

	// zero box: every rune wraps past the bottom, rest dropped up to the zero
	task automatic test_reset_box();
		send_bytes('{8'h41, 8'h42, 8'hC3, 8'h00, 8'h00});
		drain();
	endtask

	task automatic test_decode();
		set_box(100, 50, 64, 4095, NO_CURSOR);
		send_bytes('{8'h48, 8'h20, 8'h0A, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
			8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF7, 8'hBF, 8'hBF, 8'hBF});
		// bad leads, bad continuation, zero inside a sequence
		send_bytes('{8'h80, 8'hBF, 8'hF8, 8'hFF, 8'hC3, 8'h41, 8'hE2, 8'h82, 8'h00});
		drain();
	endtask

	task automatic test_cursor();
		set_box(16, 32, 512, 512, 17'd1);
		send_bytes('{8'h61, 8'h20, 8'h62, 8'h00});
		send_bytes('{8'h61, 8'h0A, 8'h62, 8'h00});
		drain();
		cfg_write(CFG_CURSOR, 17'd0);
		send_bytes('{8'h00});
		drain();
		cfg_write(CFG_CURSOR, 17'd2);
		send_bytes('{8'h61, 8'h62, 8'h00});
		drain();
		cfg_write(CFG_CURSOR, 17'd65535);
		send_bytes('{8'h61, 8'h62, 8'h00});
		drain();
		cfg_write(CFG_CURSOR, NO_CURSOR);
	endtask

	task automatic test_box_extremes();
		set_box(4095, 4095, 4095, 4095, NO_CURSOR);
		send_bytes('{8'h61, 8'h62, 8'h0A, 8'h20, 8'h63, 8'h00});
		drain();
		set_box(0, 0, 0, 4095, NO_CURSOR);
		send_bytes('{8'h61, 8'h62, 8'h63, 8'h00});
		drain();
		set_box(0, 0, 8, 16, NO_CURSOR);
		send_bytes('{8'h61, 8'h62, 8'h00, 8'h63, 8'h00});
		drain();
		cfg_write(CFG_UNUSED, 17'($urandom));
		send_bytes('{8'h61, 8'h00});
		drain();
	endtask

	// box registers change between runes of one string
	task automatic test_live_registers();
		set_box(0, 0, 4095, 4095, NO_CURSOR);
		send_bytes('{8'h61, 8'h62, 8'h63});
		drain();
		set_box(8, 0, 8, 20, NO_CURSOR);
		send_bytes('{8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h00});
		drain();
	endtask

	task automatic test_random_strings();
		int          goal;
		int          n;
		logic [16:0] cur;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ($urandom_range(0, 3))
				0:       cur = NO_CURSOR;
				1:       cur = 17'd65535;
				default: cur = 17'($urandom_range(0, 24));
			endcase
			set_box($urandom_range(0, 5) == 0 ? 4095 : $urandom_range(0, 4095),
				$urandom_range(0, 5) == 0 ? 4095 : $urandom_range(0, 4095),
				$urandom_range(0, 7) == 0 ? 4095 : $urandom_range(8, 320),
				$urandom_range(0, 7) == 0 ? 4095 : $urandom_range(16, 400), cur);
			goal = bytes_taken + RANDOM_BYTES / RANDOM_PHASES;
			while (bytes_taken < goal) begin
				if ($urandom_range(0, 6) == 0) begin
					n = $urandom_range(0, 12);
					repeat (n)
						send_byte(8'($urandom_range(1, 255)));
				end else begin
					n = $urandom_range(0, 24);
					repeat (n)
						send_rune_random();
				end
				send_byte(8'h00);
			end
			drain();
		end
	endtask

	// glyph command sink
	initial begin
		int gap;
		glyph_ch.ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			gap = $urandom_range(0, 9);
			if (gap != 0) begin
				glyph_ch.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			glyph_ch.ready = 1'b1;
			@(posedge clk);
			while (!glyph_ch.valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && glyph_ch.valid && glyph_ch.ready) begin
			if (pending_glyphs.size() == 0) begin
				$error("glyph word with no command expected");
				mismatches++;
			end else begin
				want = pending_glyphs.pop_front();
				if (glyph_ch.draw_mode !== want.draw_mode) begin
					$error("draw_mode: expected %0d, got %0d", want.draw_mode,
						glyph_ch.draw_mode);
					mismatches++;
				end
				if (glyph_ch.dest_x !== want.dest_x) begin
					$error("dest_x: expected %0d, got %0d", want.dest_x, glyph_ch.dest_x);
					mismatches++;
				end
				if (glyph_ch.dest_y !== want.dest_y) begin
					$error("dest_y: expected %0d, got %0d", want.dest_y, glyph_ch.dest_y);
					mismatches++;
				end
				if (glyph_ch.src_x !== want.src_x) begin
					$error("src_x: expected %0d, got %0d", want.src_x, glyph_ch.src_x);
					mismatches++;
				end
				if (glyph_ch.src_y !== want.src_y) begin
					$error("src_y: expected %0d, got %0d", want.src_y, glyph_ch.src_y);
					mismatches++;
				end
				if (glyph_ch.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, glyph_ch.last);
					mismatches++;
				end
				if (glyph_ch.bytes_used !== want.bytes_used) begin
					$error("bytes_used: expected %0d, got %0d", want.bytes_used,
						glyph_ch.bytes_used);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no word moved and no register write
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_ch.valid && byte_ch.ready) || (glyph_ch.valid && glyph_ch.ready)
				|| cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = CFG_LEFT;
		cfg_data          = '0;
		byte_ch.valid     = 1'b0;
		byte_ch.text_byte = '0;
		mismatches        = 0;
		bytes_taken       = 0;
		idle_cycles       = 0;
		box_left          = '0;
		box_top           = '0;
		box_w             = '0;
		box_h             = '0;
		cursor_at         = NO_CURSOR;
		pen_x             = '0;
		pen_y             = '0;
		clear_string();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_box();
		test_decode();
		test_cursor();
		test_box_extremes();
		test_live_registers();
		test_random_strings();

		drain();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
